// ===== sv/hpq_pkg.sv =====
// Shared types and constants for the binary min-heap priority queue.
package hpq_pkg;

  // Storage and field sizes
  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = 5;
  localparam int ADDR_W   = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_CHANGE  = 2'd1,
    OP_PEEK    = 2'd2,
    OP_EXTRACT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_EMPTY   = 2'd2,
    STS_BAD_POS = 2'd3
  } status_t;

  // Microprogram step addresses
  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_DISPATCH = 4'd1,
    S_UP_RD    = 4'd2,
    S_UP_CMP   = 4'd3,
    S_CHG_CMP  = 4'd4,
    S_EXT_LD   = 4'd5,
    S_DN_RD    = 4'd6,
    S_DN_CMP   = 4'd7,
    S_WR_FIN   = 4'd8,
    S_FINISH   = 4'd9
  } step_t;

  // Branch conditions tested by a control word
  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_IN_VALID = 3'd1,
    C_DISPATCH = 3'd2,
    C_AT_ROOT  = 3'd3,
    C_LESS_RD  = 3'd4,
    C_NO_CHILD = 3'd5,
    C_DN_MOVE  = 3'd6,
    C_OUT_BUSY = 3'd7
  } cond_t;

  typedef enum logic [1:0] {
    RD_NONE    = 2'd0,
    RD_OPERAND = 2'd1,
    RD_PARENT  = 2'd2,
    RD_CHILD   = 2'd3
  } rd_mode_t;

  // Parent and child moves are qualified by the step's branch condition
  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_PARENT = 2'd1,
    WR_CHILD  = 2'd2,
    WR_KEY    = 2'd3
  } wr_mode_t;

  // Multi-way dispatch selector after decode
  typedef enum logic [1:0] {
    DSP_UP   = 2'd0,
    DSP_CHG  = 2'd1,
    DSP_EXT  = 2'd2,
    DSP_DONE = 2'd3
  } dsp_t;

  typedef struct packed {
    logic     accept;
    logic     dispatch;
    logic     load_k;
    logic     out_load;
    rd_mode_t rd;
    wr_mode_t wr;
    cond_t    cond;
    step_t    t_true;
    step_t    t_false;
  } uctl_t;

  typedef struct packed {
    logic in_valid;
    logic at_root;
    logic less_rd;
    logic no_child;
    logic dn_move;
    logic out_busy;
  } cflags_t;

endpackage

// ===== sv/hpq_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read two words
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== sv/hpq_useq.sv =====
// Microprogram ROM, step counter and branch logic of the heap sequencer.
module hpq_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  hpq_pkg::cflags_t flags,
  input  hpq_pkg::dsp_t    disp,
  output hpq_pkg::uctl_t   ctl
);
  import hpq_pkg::*;

  step_t step_r;
  step_t step_nxt;

  // Control store: one word per step
  function automatic uctl_t rom(input step_t s);
    uctl_t w;
    w = '{accept: 1'b0, dispatch: 1'b0, load_k: 1'b0, out_load: 1'b0,
          rd: RD_NONE, wr: WR_NONE, cond: C_ALWAYS,
          t_true: S_IDLE, t_false: S_IDLE};
    case (s)
      S_IDLE: begin
        w.accept = 1'b1; w.cond = C_IN_VALID;
        w.t_true = S_DISPATCH; w.t_false = S_IDLE;
      end
      S_DISPATCH: begin
        w.dispatch = 1'b1; w.rd = RD_OPERAND; w.cond = C_DISPATCH;
      end
      S_UP_RD: begin
        w.rd = RD_PARENT; w.cond = C_AT_ROOT;
        w.t_true = S_WR_FIN; w.t_false = S_UP_CMP;
      end
      S_UP_CMP: begin
        w.wr = WR_PARENT; w.cond = C_LESS_RD;
        w.t_true = S_UP_RD; w.t_false = S_WR_FIN;
      end
      S_CHG_CMP: begin
        w.cond = C_LESS_RD; w.t_true = S_UP_RD; w.t_false = S_DN_RD;
      end
      S_EXT_LD: begin
        w.load_k = 1'b1; w.t_true = S_DN_RD;
      end
      S_DN_RD: begin
        w.rd = RD_CHILD; w.cond = C_NO_CHILD;
        w.t_true = S_WR_FIN; w.t_false = S_DN_CMP;
      end
      S_DN_CMP: begin
        w.wr = WR_CHILD; w.cond = C_DN_MOVE;
        w.t_true = S_DN_RD; w.t_false = S_WR_FIN;
      end
      S_WR_FIN: begin
        w.wr = WR_KEY; w.t_true = S_FINISH;
      end
      S_FINISH: begin
        w.out_load = 1'b1; w.cond = C_OUT_BUSY;
        w.t_true = S_FINISH; w.t_false = S_IDLE;
      end
      default: begin
        w.t_true = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // Dispatch table after decode
  function automatic step_t dsp_target(input dsp_t d);
    step_t s;
    case (d)
      DSP_UP:  s = S_UP_RD;
      DSP_CHG: s = S_CHG_CMP;
      DSP_EXT: s = S_EXT_LD;
      default: s = S_FINISH;
    endcase
    return s;
  endfunction

  assign ctl = rom(step_r);

  // Pick the next step
  always_comb begin
    case (ctl.cond)
      C_ALWAYS:   step_nxt = ctl.t_true;
      C_IN_VALID: step_nxt = flags.in_valid ? ctl.t_true : ctl.t_false;
      C_DISPATCH: step_nxt = dsp_target(disp);
      C_AT_ROOT:  step_nxt = flags.at_root  ? ctl.t_true : ctl.t_false;
      C_LESS_RD:  step_nxt = flags.less_rd  ? ctl.t_true : ctl.t_false;
      C_NO_CHILD: step_nxt = flags.no_child ? ctl.t_true : ctl.t_false;
      C_DN_MOVE:  step_nxt = flags.dn_move  ? ctl.t_true : ctl.t_false;
      C_OUT_BUSY: step_nxt = flags.out_busy ? ctl.t_true : ctl.t_false;
      default:    step_nxt = S_IDLE;
    endcase
  end

  // Hold the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== sv/binary_min_heap_priority_queue.sv =====
// Top level of the binary min-heap priority queue.
// A request carries an operation (insert, change key at a position, peek, extract) and
// returns one result with the minimum key, the entry count and a status. A microprogram
// walks one root-to-leaf path through the heap RAM, each level with a read step and then
// a compare-and-write step. After decode, peek and rejected requests go straight to the
// result; insert sifts up, extract takes the last entry and sifts down, and change-key
// compares once and then sifts up or down. The moving key is then written at the hole
// and the result is loaded into the output register. One request is worked at a time; the
// next one is accepted as soon as the result sits in the output register, even while the
// output side stalls. The heap RAM needs no clearing after reset.
module binary_min_heap_priority_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_op,
  input  logic signed [hpq_pkg::KEY_W-1:0] in_key,
  input  logic [hpq_pkg::CNT_W-1:0]        in_position,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [hpq_pkg::KEY_W-1:0] out_min_key,
  output logic [hpq_pkg::CNT_W-1:0]        out_entry_count,
  output logic [1:0]                      out_status
);
  import hpq_pkg::*;

  uctl_t   ctl;
  cflags_t flags;
  dsp_t    disp;

  op_t                op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [KEY_W-1:0]   k_r, k_nxt;
  logic [KEY_W-1:0]   res_r, res_nxt;
  logic [KEY_W-1:0]   root_r, root_nxt;
  status_t            status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]   out_min_r, out_min_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  status_t            out_sts_r, out_sts_nxt;

  status_t            status_chk;
  logic               accept_fire;
  logic               out_fire;
  logic [CNT_W:0]     child_l;
  logic [CNT_W:0]     child_r;
  logic               l_ok;
  logic               r_ok;
  logic               l_less;
  logic               r_less;
  logic [KEY_W-1:0]   best_l;
  logic [KEY_W-1:0]   child_key;
  logic [CNT_W-1:0]   child_idx;
  logic               less_rd;
  logic               dn_move;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [KEY_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr_a;
  logic [ADDR_W-1:0]  ram_raddr_b;
  logic [KEY_W-1:0]   rd_a;
  logic [KEY_W-1:0]   rd_b;

  // Map a one-based heap position to a RAM address
  function automatic logic [ADDR_W-1:0] pos_addr(input logic [CNT_W:0] p);
    logic [CNT_W:0] a;
    a = p - (CNT_W+1)'(1);
    return a[ADDR_W-1:0];
  endfunction

  hpq_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .disp  (disp),
    .ctl   (ctl)
  );

  hpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Handshake
  assign in_stall    = !ctl.accept;
  assign accept_fire = ctl.accept && in_valid;

  // Check the request against the current count
  always_comb begin
    case (op_r)
      OP_INSERT:
        status_chk = (count_r >= CNT_W'(CAPACITY)) ? STS_FULL : STS_OK;
      OP_CHANGE:
        status_chk = (pos_r == '0 || pos_r > count_r) ? STS_BAD_POS : STS_OK;
      default:
        status_chk = (count_r == '0) ? STS_EMPTY : STS_OK;
    endcase
    if (status_chk != STS_OK) begin
      disp = DSP_DONE;
    end else begin
      case (op_r)
        OP_INSERT:  disp = DSP_UP;
        OP_CHANGE:  disp = DSP_CHG;
        OP_EXTRACT: disp = DSP_EXT;
        default:    disp = DSP_DONE;
      endcase
    end
  end

  // Compare the moving key against the read data
  assign child_l   = {i_r, 1'b0};
  assign child_r   = {i_r, 1'b1};
  assign l_ok      = child_l <= {1'b0, count_r};
  assign r_ok      = child_r <= {1'b0, count_r};
  assign less_rd   = $signed(k_r) < $signed(rd_a);
  assign l_less    = l_ok && ($signed(rd_a) < $signed(k_r));
  assign best_l    = l_less ? rd_a : k_r;
  assign r_less    = r_ok && ($signed(rd_b) < $signed(best_l));
  assign dn_move   = l_less || r_less;
  assign child_key = r_less ? rd_b : rd_a;
  assign child_idx = r_less ? child_r[CNT_W-1:0] : child_l[CNT_W-1:0];

  assign flags = '{in_valid: in_valid,
                   at_root:  (i_r == CNT_W'(1)),
                   less_rd:  less_rd,
                   no_child: !l_ok,
                   dn_move:  dn_move,
                   out_busy: out_valid_r && out_stall};

  // Drive RAM reads
  always_comb begin
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    case (ctl.rd)
      RD_OPERAND:
        ram_raddr_a = (op_r == OP_CHANGE) ? pos_addr({1'b0, pos_r})
                                          : pos_addr({1'b0, count_r});
      RD_PARENT:
        ram_raddr_a = pos_addr({2'b00, i_r[CNT_W-1:1]});
      RD_CHILD: begin
        ram_raddr_a = pos_addr(child_l);
        ram_raddr_b = pos_addr(child_r);
      end
      default: begin
        ram_raddr_a = '0;
      end
    endcase
  end

  // Drive RAM writes at the hole position
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = k_r;
    case (ctl.wr)
      WR_PARENT: begin
        ram_we    = less_rd;
        ram_wdata = rd_a;
      end
      WR_CHILD: begin
        ram_we    = dn_move;
        ram_wdata = child_key;
      end
      WR_KEY: begin
        ram_we    = 1'b1;
        ram_wdata = k_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end
  assign ram_waddr = pos_addr({1'b0, i_r});

  // Next values of the datapath registers
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    res_nxt       = res_r;
    root_nxt      = root_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_min_nxt   = out_min_r;
    out_cnt_nxt   = out_cnt_r;
    out_sts_nxt   = out_sts_r;
    out_fire      = ctl.out_load && !flags.out_busy;

    // Latch the request
    if (accept_fire) begin
      op_nxt  = op_t'(in_op);
      key_nxt = in_key;
      pos_nxt = in_position;
    end

    // Decode and set up the sift
    if (ctl.dispatch) begin
      status_nxt = status_chk;
      if (status_chk == STS_OK) begin
        case (op_r)
          OP_INSERT: begin
            count_nxt = count_r + CNT_W'(1);
            i_nxt     = count_r + CNT_W'(1);
            k_nxt     = key_r;
          end
          OP_CHANGE: begin
            i_nxt = pos_r;
            k_nxt = key_r;
          end
          OP_EXTRACT: begin
            res_nxt   = root_r;
            count_nxt = count_r - CNT_W'(1);
          end
          default: begin
            count_nxt = count_r;
          end
        endcase
      end
    end

    // Take the last entry as the moving key
    if (ctl.load_k) begin
      k_nxt = rd_a;
      i_nxt = CNT_W'(1);
    end

    // Advance the hole
    if (ctl.wr == WR_PARENT && less_rd) begin
      i_nxt = i_r >> 1;
    end
    if (ctl.wr == WR_CHILD && dn_move) begin
      i_nxt = child_idx;
    end

    // Mirror the root entry
    if (ram_we && i_r == CNT_W'(1)) begin
      root_nxt = ram_wdata;
    end

    // Drop a taken result, load a new one
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_fire) begin
      out_valid_nxt = 1'b1;
      out_cnt_nxt   = count_r;
      out_sts_nxt   = status_r;
      if (op_r == OP_EXTRACT && status_r == STS_OK) begin
        out_min_nxt = res_r;
      end else if (count_r == '0) begin
        out_min_nxt = '0;
      end else begin
        out_min_nxt = root_r;
      end
    end
  end

  // Hold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    pos_r     <= pos_nxt;
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    res_r     <= res_nxt;
    root_r    <= root_nxt;
    status_r  <= status_nxt;
    out_min_r <= out_min_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_sts_r <= out_sts_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_min_key     = out_min_r;
  assign out_entry_count = out_cnt_r;
  assign out_status      = out_sts_r;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in progress");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (i_r != '0 && i_r <= CNT_W'(CAPACITY)))
    else $error("heap write outside positions 1..CAPACITY");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept |-> !ram_we)
    else $error("heap written while waiting for a request");

endmodule
